// ===== rtl/core/pteu_pkg.sv =====
// Shared types and constants for the page table entry rights update block.
`default_nettype none

package pteu_pkg;

    // Entry field layout
    localparam logic [31:0] ACC_MASK   = 32'h0000_001C;
    localparam logic [31:0] CACHE_BIT  = 32'h0000_0080;
    localparam logic [31:0] LEAF_TYPE  = 32'h0000_0002;
    localparam int unsigned ACC_LSB    = 2;

    // Operation codes
    typedef enum logic [1:0] {
        FN_CREATE = 2'd0,
        FN_SET    = 2'd1,
        FN_ADD    = 2'd2,
        FN_REMOVE = 2'd3
    } t_func;

    // SRMMU access permission codes
    typedef enum logic [2:0] {
        ACC_RO     = 3'd0,
        ACC_RW     = 3'd1,
        ACC_RX     = 3'd2,
        ACC_RWX    = 3'd3,
        ACC_XO     = 3'd4,
        ACC_RO_RW  = 3'd5,
        ACC_NO_RX  = 3'd6,
        ACC_NO_RWX = 3'd7
    } t_acc;

    // Page table levels
    localparam logic [1:0] LVL_16M  = 2'd0;
    localparam logic [1:0] LVL_256K = 2'd1;

    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] entry_in;
        logic [3:0]  rights;
        logic        normal_memory;
        logic [35:0] phys_addr;
        logic [1:0]  table_level;
    } t_req;

    typedef struct packed {
        logic [31:0] entry_out;
        logic        changed;
        logic        misaligned;
    } t_rsp;

endpackage

`default_nettype wire

// ===== rtl/core/pteu_req_if.sv =====
// Request channel interface: valid/ready handshake with a request payload.
`default_nettype none

interface pteu_req_if
    import pteu_pkg::*;
();
    logic valid;
    logic ready;
    t_req payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/pteu_rsp_if.sv =====
// Response channel interface: valid/ready handshake with a result payload.
`default_nettype none

interface pteu_rsp_if
    import pteu_pkg::*;
();
    logic valid;
    logic ready;
    t_rsp payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/pte_access_rights_update.sv =====
// Top level: SRMMU page table entry access rights update pipeline.
// Usage:
//   i_req (sink) takes one request per cycle: an operation code, the current
//   entry word, a rights mask, the cacheable request, a physical address and
//   a table level. o_rsp (source) returns the updated entry, the changed
//   flag and the misaligned flag, one response per request, in order.
//   Path: a taken request goes into the input register, then through the
//   update logic into the result register, which drives o_rsp.valid and
//   the response payload.
//   Throughput: one request per cycle, sustained, as long as the receiver
//   keeps o_rsp.ready high; both stages advance together.
//   Stall: when o_rsp.ready is low the result register holds its response,
//   the input stage keeps filling until it too holds a request, and only
//   then does i_req.ready drop. Up to two requests are held in flight.
//   Reset (i_rst_n low, synchronous): both stages empty, o_rsp.valid low,
//   i_req.ready high on the first cycle after reset.
//   No state carries over between requests; each response depends only on
//   its own request.
`default_nettype none

module pte_access_rights_update
    import pteu_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    pteu_req_if.sink    i_req,
    pteu_rsp_if.source  o_rsp
);

    // input stage
    logic r_in_vld;
    t_req r_in;
    // result stage
    logic r_out_vld;
    t_rsp r_out;
    t_rsp n_out;

    logic out_adv;  // result register may load
    logic in_adv;   // input register may load

    assign out_adv     = !r_out_vld || o_rsp.ready;
    assign in_adv      = !r_in_vld || out_adv;
    assign i_req.ready = in_adv;

    pteu_calc u_calc (
        .i_req (r_in),
        .o_rsp (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (in_adv) r_in_vld <= i_req.valid;
            if (out_adv) r_out_vld <= r_in_vld;
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (in_adv && i_req.valid) r_in <= i_req.payload;
        if (out_adv && r_in_vld) r_out <= n_out;
    end

    assign o_rsp.valid   = r_out_vld;
    assign o_rsp.payload = r_out;

endmodule

`default_nettype wire

// ===== rtl/core/pteu_calc.sv =====
// Combinational entry update: create, set, add rights and remove rights.
`default_nettype none

module pteu_calc
    import pteu_pkg::*;
(
    input  wire t_req i_req,
    output t_rsp      o_rsp
);

    typedef struct packed {
        logic       hit;
        logic [2:0] code;
    } t_upd;

    function automatic logic [2:0] f_rights_to_acc(input logic [3:0] r);
        logic [2:0] a;
        case (r)
            4'd0, 4'd1, 4'd4, 4'd5, 4'd8: a = ACC_NO_RX;
            4'd2, 4'd3, 4'd6, 4'd7:       a = ACC_NO_RWX;
            4'd9:                         a = ACC_XO;
            4'd10, 4'd14:                 a = ACC_RW;
            4'd11, 4'd15:                 a = ACC_RWX;
            4'd12:                        a = ACC_RO;
            4'd13:                        a = ACC_RX;
            default:                      a = ACC_NO_RX;
        endcase
        return a;
    endfunction

    function automatic t_upd f_upd(input t_acc c);
        t_upd u;
        u.hit  = 1'b1;
        u.code = c;
        return u;
    endfunction

    // r[3] user, r[2] read, r[1] write, r[0] execute
    function automatic t_upd f_grant(input logic [2:0] o, input logic [3:0] r);
        t_upd u;
        u = '0;
        case (o)
            ACC_RO: begin
                if (r == 4'b0110)         u = f_upd(ACC_RO_RW);
                else if (r[1] && r[0])    u = f_upd(ACC_RWX);
                else if (r[1])            u = f_upd(ACC_RW);
                else if (r[0])            u = f_upd(ACC_RX);
            end
            ACC_RW:  if (r[0]) u = f_upd(ACC_RWX);
            ACC_RX:  if (r[1]) u = f_upd(ACC_RWX);
            ACC_RWX: u = '0;
            ACC_XO: begin
                if (r[1])      u = f_upd(ACC_RWX);
                else if (r[2]) u = f_upd(ACC_RX);
            end
            ACC_RO_RW: begin
                if (r[0])              u = f_upd(ACC_RWX);
                else if (r[3] && r[1]) u = f_upd(ACC_RW);
            end
            ACC_NO_RX: begin
                if (r[3]) begin
                    if (r[1])      u = f_upd(ACC_RWX);
                    else if (r[0]) u = f_upd(ACC_RX);
                end else if (r[1]) begin
                    u = f_upd(ACC_NO_RWX);
                end
            end
            default: if (r[3] && (r[2:0] != 3'b000)) u = f_upd(ACC_RWX);
        endcase
        return u;
    endfunction

    function automatic t_upd f_revoke(input logic [2:0] o, input logic [3:0] r);
        t_upd u;
        u = '0;
        case (o)
            ACC_RX: begin
                if (r[2])      u = f_upd(ACC_XO);
                else if (r[0]) u = f_upd(ACC_RO);
            end
            ACC_RW:    if (r[1]) u = f_upd(ACC_RO);
            ACC_RWX: begin
                if (r[1]) begin
                    if (r[0])      u = f_upd(ACC_RO);
                    else if (r[2]) u = f_upd(ACC_XO);
                    else           u = f_upd(ACC_RX);
                end else if (r[0]) begin
                    u = f_upd(ACC_RW);
                end
            end
            ACC_RO_RW:  if (r[1]) u = f_upd(ACC_RO);
            ACC_NO_RWX: if (r[1]) u = f_upd(ACC_NO_RX);
            default:    u = '0;  // nothing left to remove
        endcase
        return u;
    endfunction

    logic [31:0] attr;
    logic [2:0]  cur_acc;
    t_upd        upd;
    logic        mis;

    assign attr = (32'(f_rights_to_acc(i_req.rights)) << ACC_LSB)
                | (i_req.normal_memory ? CACHE_BIT : 32'h0);
    assign cur_acc = i_req.entry_in[ACC_LSB +: 3];

    always_comb begin
        case (i_req.table_level)
            LVL_16M:  mis = (i_req.phys_addr[23:0] != 24'h0);
            LVL_256K: mis = (i_req.phys_addr[17:0] != 18'h0);
            default:  mis = (i_req.phys_addr[11:0] != 12'h0);
        endcase
    end

    always_comb begin
        upd   = '0;
        o_rsp = '0;
        case (i_req.func)
            FN_CREATE: begin
                o_rsp.entry_out  = LEAF_TYPE | attr | i_req.phys_addr[35:4];
                o_rsp.changed    = 1'b1;
                o_rsp.misaligned = mis;
            end
            FN_SET: begin
                o_rsp.entry_out = (i_req.entry_in & ~(ACC_MASK | CACHE_BIT)) | attr;
                o_rsp.changed   = 1'b1;
            end
            default: begin
                upd = (i_req.func == FN_ADD) ? f_grant(cur_acc, i_req.rights)
                                             : f_revoke(cur_acc, i_req.rights);
                o_rsp.entry_out = upd.hit
                    ? ((i_req.entry_in & ~ACC_MASK) | (32'(upd.code) << ACC_LSB))
                    : i_req.entry_in;
                o_rsp.changed   = upd.hit;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== verif/pte_access_rights_update_tb.sv =====
// Testbench for pte_access_rights_update: directed and random requests checked against a predictor.

module pte_access_rights_update_tb;
    import pteu_pkg::*;

    // Random part size and the few fixed waits of the run
    localparam int unsigned N_RAND_REQS  = 1130;
    localparam int unsigned PHASE_LEN    = 140;
    localparam int unsigned HOLD_CYCLES  = 60;     // long receiver hold-off
    localparam int unsigned DRAIN_CYCLES = 8;      // pipeline is two deep
    localparam int unsigned BURST_START  = 300;
    localparam int unsigned QUIET_POINT  = 700;

    // Rights mask bits
    localparam logic [3:0] RT_USER  = 4'b1000;
    localparam logic [3:0] RT_READ  = 4'b0100;
    localparam logic [3:0] RT_WRITE = 4'b0010;
    localparam logic [3:0] RT_EXEC  = 4'b0001;

    // One row of the directed table; rsp is only used when known is set
    typedef struct {
        t_req req;
        bit   known;
        t_rsp rsp;
    } t_vec;

    logic i_clk;
    logic i_rst_n;

    pteu_req_if req_ch();
    pteu_rsp_if rsp_ch();

    t_vec        vec_tbl[$];
    t_rsp        exp_pte_q[$];      // responses still owed by the block, oldest first
    int unsigned n_errors    = 0;
    int unsigned req_gap_max = 16;
    int unsigned rsp_gap_max = 16;
    bit          rsp_hold    = 1'b0;

    pte_access_rights_update u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Run limit: far above the slowest legal run (every gap and stall at its maximum)
    initial begin
        #5_000_000;
        $display("pte_access_rights_update test failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Rights mask to SRMMU access code. Anything without user access ends up
    // as one of the supervisor-only codes.
    function automatic logic [2:0] rights_acc(input logic [3:0] r);
        case (r)
            4'h9:                   return ACC_XO;
            4'hA, 4'hE:             return ACC_RW;
            4'hB, 4'hF:             return ACC_RWX;
            4'hC:                   return ACC_RO;
            4'hD:                   return ACC_RX;
            4'h2, 4'h3, 4'h6, 4'h7: return ACC_NO_RWX;
            default:                return ACC_NO_RX;
        endcase
    endfunction

    // Page offset bits for a table level; level three is treated as 4KB
    function automatic logic [35:0] page_mask(input logic [1:0] lvl);
        case (lvl)
            LVL_16M:  return 36'h0_00FF_FFFF;
            LVL_256K: return 36'h0_0003_FFFF;
            default:  return 36'h0_0000_0FFF;
        endcase
    endfunction

    // Access code after granting (grant=1) or revoking rights. Returns the
    // current code when the operation has nothing to do.
    function automatic logic [2:0] next_acc(input logic [2:0] cur, input logic [3:0] r,
                                            input bit grant);
        logic       u;
        logic       rd;
        logic       w;
        logic       x;
        logic [2:0] nxt;
        u   = |(r & RT_USER);
        rd  = |(r & RT_READ);
        w   = |(r & RT_WRITE);
        x   = |(r & RT_EXEC);
        nxt = cur;
        if (grant) begin
            case (cur)
                ACC_RO: begin
                    if (r == (RT_READ | RT_WRITE)) nxt = ACC_RO_RW;
                    else if (w && x)               nxt = ACC_RWX;
                    else if (w)                    nxt = ACC_RW;
                    else if (x)                    nxt = ACC_RX;
                end
                ACC_RW:     if (x) nxt = ACC_RWX;
                ACC_RX:     if (w) nxt = ACC_RWX;
                ACC_XO: begin
                    if (w)       nxt = ACC_RWX;
                    else if (rd) nxt = ACC_RX;
                end
                ACC_RO_RW: begin
                    if (x)           nxt = ACC_RWX;
                    else if (u && w) nxt = ACC_RW;
                end
                ACC_NO_RX: begin
                    if (u && w)       nxt = ACC_RWX;
                    else if (u && x)  nxt = ACC_RX;
                    else if (!u && w) nxt = ACC_NO_RWX;
                end
                ACC_NO_RWX: if (u && (rd || w || x)) nxt = ACC_RWX;
                default: ;
            endcase
        end else begin
            case (cur)
                ACC_RX: begin
                    if (rd)     nxt = ACC_XO;
                    else if (x) nxt = ACC_RO;
                end
                ACC_RW, ACC_RO_RW: if (w) nxt = ACC_RO;
                ACC_RWX: begin
                    if (w && x)       nxt = ACC_RO;
                    else if (w && rd) nxt = ACC_XO;
                    else if (w)       nxt = ACC_RX;
                    else if (x)       nxt = ACC_RW;
                end
                ACC_NO_RWX: if (w) nxt = ACC_NO_RX;
                default: ;   // RO, XO, NO_RX have nothing to take away
            endcase
        end
        return nxt;
    endfunction

    function automatic t_rsp predict_pte_update(input t_req r);
        t_rsp        p;
        logic [2:0]  acc;
        logic [31:0] attr;
        p.entry_out  = r.entry_in;
        p.changed    = 1'b0;
        p.misaligned = 1'b0;
        // cacheable at bit 7, access code at bits 4:2
        attr = {24'b0, r.normal_memory, 2'b00, rights_acc(r.rights), 2'b00};
        case (r.func)
            FN_CREATE: begin
                // address bits go in unmasked even when misaligned
                p.misaligned = |(r.phys_addr & page_mask(r.table_level));
                p.entry_out  = LEAF_TYPE | attr | r.phys_addr[35:4];
                p.changed    = 1'b1;
            end
            FN_SET: begin
                p.entry_out = (r.entry_in & ~(ACC_MASK | CACHE_BIT)) | attr;
                p.changed   = 1'b1;
            end
            default: begin
                acc         = next_acc(r.entry_in[4:2], r.rights, r.func == FN_ADD);
                p.changed   = (acc != r.entry_in[4:2]);
                p.entry_out = {r.entry_in[31:5], acc, r.entry_in[1:0]};
            end
        endcase
        return p;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Entry word with a given access code and a fixed pattern elsewhere,
    // cacheable bit set, so kept bits are visible.
    function automatic logic [31:0] acc_word(input logic [2:0] c);
        return 32'hA5A5_A581 | {27'b0, c, 2'b00};
    endfunction

    function automatic t_req rand_req();
        t_req r;
        r.func                = 2'($urandom_range(0, 3));
        r.entry_in            = $urandom;
        r.rights              = 4'($urandom_range(0, 15));
        r.normal_memory       = 1'($urandom_range(0, 1));
        r.phys_addr[31:0]     = $urandom;
        r.phys_addr[35:32]    = 4'($urandom_range(0, 15));
        r.table_level         = 2'($urandom_range(0, 3));
        // page-aligned half the time, otherwise misaligned is almost always set
        if ($urandom_range(0, 1) == 1)
            r.phys_addr = r.phys_addr & ~page_mask(r.table_level);
        return r;
    endfunction

    task automatic push_vec(input logic [1:0] fn, input logic [31:0] entry,
                            input logic [3:0] rts, input logic nm,
                            input logic [35:0] pa, input logic [1:0] lvl,
                            input bit known = 1'b0, input logic [31:0] x_entry = '0,
                            input logic x_changed = 1'b0, input logic x_mis = 1'b0);
        t_vec v;
        v.req.func           = fn;
        v.req.entry_in       = entry;
        v.req.rights         = rts;
        v.req.normal_memory  = nm;
        v.req.phys_addr      = pa;
        v.req.table_level    = lvl;
        v.known              = known;
        v.rsp.entry_out      = x_entry;
        v.rsp.changed        = x_changed;
        v.rsp.misaligned     = x_mis;
        vec_tbl.push_back(v);
    endtask

    // Offer one request after a random gap and hold it until accepted.
    // valid stays high across back-to-back requests (gap of zero).
    task automatic send_req(input t_req r, input bit known, input t_rsp rsp);
        int unsigned gap;
        gap = $urandom_range(0, req_gap_max);
        if (gap != 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid   <= 1'b1;
        req_ch.payload <= r;
        do @(posedge i_clk); while (!req_ch.ready);
        exp_pte_q.push_back(known ? rsp : predict_pte_update(r));
    endtask

    // ------------------------------------------------------------------
    // Response side: random stalls per response, plus one long hold-off
    // on request from the stimulus process.
    // ------------------------------------------------------------------
    initial begin
        int unsigned stall;
        rsp_ch.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (rsp_hold) begin
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                rsp_hold = 1'b0;
            end
            stall = $urandom_range(0, rsp_gap_max);
            if (stall != 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            rsp_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!rsp_ch.valid);
        end
    end

    // Every accepted response is matched against the oldest expectation
    always @(posedge i_clk) begin : rsp_check
        t_rsp want;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (exp_pte_q.size() == 0) begin
                $error("unexpected response: entry_out %h", rsp_ch.payload.entry_out);
                n_errors++;
            end else begin
                want = exp_pte_q.pop_front();
                if (rsp_ch.payload.entry_out !== want.entry_out) begin
                    $error("entry_out: expected %h, got %h",
                           want.entry_out, rsp_ch.payload.entry_out);
                    n_errors++;
                end
                if (rsp_ch.payload.changed !== want.changed) begin
                    $error("changed: expected %b, got %b",
                           want.changed, rsp_ch.payload.changed);
                    n_errors++;
                end
                if (rsp_ch.payload.misaligned !== want.misaligned) begin
                    $error("misaligned: expected %b, got %b",
                           want.misaligned, rsp_ch.payload.misaligned);
                    n_errors++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        int unsigned k;
        req_ch.valid   <= 1'b0;
        req_ch.payload <= '0;
        i_rst_n        <= 1'b0;

        // Create: all-zero, all-ones, aligned and misaligned at each level,
        // level three behaving as a 4KB page
        push_vec(FN_CREATE, 32'h0000_0000, 4'h0, 1'b0, 36'h0_0000_0000, LVL_16M,
                 1'b1, 32'h0000_001A, 1'b1, 1'b0);
        push_vec(FN_CREATE, 32'hFFFF_FFFF, 4'hF, 1'b1, 36'hF_FFFF_FFFF, LVL_16M,
                 1'b1, 32'hFFFF_FFFF, 1'b1, 1'b1);
        push_vec(FN_CREATE, 32'h0000_0000, 4'hC, 1'b1, 36'h0_0004_0000, LVL_256K,
                 1'b1, 32'h0000_4082, 1'b1, 1'b0);
        push_vec(FN_CREATE, 32'h1234_5678, 4'h9, 1'b0, 36'h0_0002_0000, LVL_256K);
        push_vec(FN_CREATE, 32'h0000_0000, 4'hD, 1'b1, 36'h8_0000_1000, 2'd2);
        push_vec(FN_CREATE, 32'h0000_0000, 4'h6, 1'b0, 36'h0_0000_0800, 2'd3);
        push_vec(FN_CREATE, 32'h0000_0000, 4'hA, 1'b1, 36'h1_0100_0000, LVL_16M);
        // Set: an all-ones entry with no rights, an all-zero entry with all rights
        push_vec(FN_SET, 32'hFFFF_FFFF, 4'h0, 1'b0, 36'h0, LVL_16M,
                 1'b1, 32'hFFFF_FF7B, 1'b1, 1'b0);
        push_vec(FN_SET, 32'h0000_0000, 4'hF, 1'b1, 36'h0, LVL_16M,
                 1'b1, 32'h0000_008C, 1'b1, 1'b0);
        push_vec(FN_SET, 32'h1234_5678, 4'hE, 1'b0, 36'hF_FFFF_FFFF, 2'd3);
        // Add: nothing to grant on full access, then paths from RO, XO, RO_RW, NO_RX and NO_RWX
        push_vec(FN_ADD, acc_word(ACC_RWX), 4'hF, 1'b0, 36'h0, LVL_16M,
                 1'b1, 32'hA5A5_A58D, 1'b0, 1'b0);
        push_vec(FN_ADD, acc_word(ACC_RO),     RT_READ | RT_WRITE, 1'b0, 36'h0, LVL_16M);
        push_vec(FN_ADD, acc_word(ACC_RO),     RT_WRITE | RT_EXEC, 1'b0, 36'h0, LVL_16M);
        push_vec(FN_ADD, acc_word(ACC_RO),     RT_EXEC,            1'b0, 36'h0, LVL_16M);
        push_vec(FN_ADD, acc_word(ACC_XO),     RT_READ,            1'b0, 36'h0, LVL_16M);
        push_vec(FN_ADD, acc_word(ACC_RO_RW),  RT_USER | RT_WRITE, 1'b0, 36'h0, LVL_16M);
        push_vec(FN_ADD, acc_word(ACC_NO_RX),  RT_USER | RT_EXEC,  1'b0, 36'h0, LVL_16M);
        push_vec(FN_ADD, acc_word(ACC_NO_RX),  RT_WRITE,           1'b0, 36'h0, LVL_16M);
        push_vec(FN_ADD, acc_word(ACC_NO_RWX), RT_USER | RT_READ,  1'b0, 36'h0, LVL_16M);
        // Remove: the write, read/write and exec paths out of full access, read/exec,
        // supervisor rwx, and nothing to remove from read-only
        push_vec(FN_REMOVE, acc_word(ACC_RWX),    RT_WRITE,           1'b0, 36'h0, LVL_16M);
        push_vec(FN_REMOVE, acc_word(ACC_RWX),    RT_READ | RT_WRITE, 1'b0, 36'h0, LVL_16M);
        push_vec(FN_REMOVE, acc_word(ACC_RWX),    RT_EXEC,            1'b0, 36'h0, LVL_16M);
        push_vec(FN_REMOVE, acc_word(ACC_RX),     RT_READ,            1'b0, 36'h0, LVL_16M);
        push_vec(FN_REMOVE, acc_word(ACC_NO_RWX), RT_WRITE,           1'b0, 36'h0, LVL_16M);
        push_vec(FN_REMOVE, acc_word(ACC_RO), 4'hF, 1'b0, 36'h0, LVL_16M,
                 1'b1, 32'hA5A5_A581, 1'b0, 1'b0);

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (vec_tbl[i])
            send_req(vec_tbl[i].req, vec_tbl[i].known, vec_tbl[i].rsp);

        // Random part, in phases of differing idle behavior on both sides
        for (k = 0; k < N_RAND_REQS; k++) begin
            if (k % PHASE_LEN == 0) begin
                case ((k / PHASE_LEN) % 4)
                    0: begin
                        req_gap_max = 16;
                        rsp_gap_max = 16;
                    end
                    1: begin           // no idling at all
                        req_gap_max = 0;
                        rsp_gap_max = 0;
                    end
                    2: begin           // fast sender, slow receiver
                        req_gap_max = 2;
                        rsp_gap_max = 16;
                    end
                    default: begin     // slow sender, fast receiver
                        req_gap_max = 16;
                        rsp_gap_max = 1;
                    end
                endcase
            end
            if (k == BURST_START) begin
                // receiver stops while back-to-back requests keep coming:
                // both pipeline stages fill and the input must stall
                req_gap_max = 0;
                rsp_hold    = 1'b1;
            end
            if (k == QUIET_POINT) begin
                // sender goes quiet until every owed response has come out
                req_ch.valid <= 1'b0;
                do @(posedge i_clk); while (exp_pte_q.size() != 0);
            end
            send_req(rand_req(), 1'b0, '0);
        end

        req_ch.valid <= 1'b0;
        while (exp_pte_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (n_errors == 0)
            $display("pte_access_rights_update test passed");
        else
            $display("pte_access_rights_update test failed");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/pteu_pkg.sv
rtl/core/pteu_req_if.sv
rtl/core/pteu_rsp_if.sv
rtl/core/pteu_calc.sv
rtl/core/pte_access_rights_update.sv
verif/pte_access_rights_update_tb.sv
